### hw/rtl/uet_pkg.sv
// ----------------------------------------------------------------------------
// uet_pkg
// Shared types and codes for the undirected edge table: request kinds,
// result status codes, controller states and the result record.
// ----------------------------------------------------------------------------
package uet_pkg;

	// Default sizes of the node and edge stores
	localparam int MAX_NODES_DEF = 64;
	localparam int MAX_EDGES_DEF = 1024;

	// Fixed field widths
	localparam int NODE_W   = 6;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 3;
	localparam int DEG_W    = 6;

	// Most neighbour results one list request may give
	localparam logic [NODE_W-1:0] RESULT_CAP = 6'd63;

	// Request kinds
	typedef enum logic [KIND_W-1:0] {
		K_ADD_NODE = 2'd0,
		K_ADD_EDGE = 2'd1,
		K_LIST     = 2'd2
	} kind_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_SELF       = 3'd1,
		ST_DUP        = 3'd2,
		ST_RANGE      = 3'd3,
		ST_EDGES_FULL = 3'd4,
		ST_NODES_FULL = 3'd5
	} status_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DEG_LO,
		S_DEG_HI,
		S_REPORT
	} state_t;

	// One result, without the top node
	typedef struct packed {
		status_t           status;
		logic [NODE_W-1:0] node_index;
		logic              neighbour_valid;
		logic              last;
	} res_t;

endpackage

### hw/rtl/undirected_edge_table_top.sv
// ----------------------------------------------------------------------------
// undirected_edge_table_top
// Results: add-node, bad kind and range or self-loop rejections give their one
//   result in the cycle after the transfer; add-edge scans the stored edges,
//   stopping on a duplicate, then, unless the store is full, bumps the degrees
//   of both ends and reports; list gives its last result when the scan ends or
//   once 63 neighbours are found, streaming neighbours out while the scan runs.
// Throughput: one request at a time, set by the one-read-per-cycle scan of
//   the edge memory (busy drops in the cycle the last result is given).
// Reset: counts, degree valid bits and the tracked top node clear at once; the
// edge memory and result registers are not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module undirected_edge_table_top
	import uet_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int MAX_EDGES = MAX_EDGES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [KIND_W-1:0]   kind,
	input  logic [NODE_W-1:0]   node_a,
	input  logic [NODE_W-1:0]   node_b,
	output logic                strobe,
	output logic [STATUS_W-1:0] status,
	output logic [NODE_W-1:0]   node_index,
	output logic                neighbour_valid,
	output logic                last,
	output logic [NODE_W-1:0]   top_node
);

	// Derived sizes
	localparam int NC_W  = $clog2(MAX_NODES + 1);
	localparam int CMP_W = (NC_W > NODE_W) ? NC_W : NODE_W;
	localparam int EC_W  = $clog2(MAX_EDGES + 1);
	localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int DN    = (MAX_NODES < 64) ? MAX_NODES : 64;
	localparam int NA_W  = $clog2(DN);
	localparam int EDGE_W = 2 * NODE_W;

	// Control state
	state_t               state_q, state_d;
	logic [NC_W-1:0]      node_count_q;
	logic [EC_W-1:0]      edge_count_q;
	logic [NODE_W-1:0]    best_node_q;
	logic [DEG_W-1:0]     best_deg_q;
	logic [DN-1:0]        deg_vld_q;
	logic                 rd_vld_s1;
	logic                 pend_vld_q;
	logic [NODE_W-1:0]    n_q;
	logic                 strobe_q;

	// Request and scan payload
	logic [KIND_W-1:0]    kind_q;
	logic [NODE_W-1:0]    lo_q, hi_q, a_q;
	logic [EC_W-1:0]      rd_idx_q;
	logic [NODE_W-1:0]    pend_idx_q;
	res_t                 res_q, res_d;
	logic [NODE_W-1:0]    top_q;

	// Memories
	logic [EDGE_W-1:0]    edge_mem [MAX_EDGES];
	logic [EDGE_W-1:0]    edge_rdata_s1;
	logic [DEG_W-1:0]     deg_mem [DN];
	logic [DEG_W-1:0]     deg_rdata_s1;
	logic                 deg_rvld_s1;

	// Datapath and control signals
	logic                 accept;
	logic                 a_out, b_out;
	logic [NODE_W-1:0]    lo_in, hi_in;
	logic                 issue, full, scan_done;
	logic [NODE_W-1:0]    e_lo, e_hi;
	logic                 dup, hit;
	logic [NODE_W-1:0]    other;
	logic [NA_W-1:0]      deg_raddr;
	logic [DEG_W-1:0]     deg_cur, deg_new;
	logic [NODE_W-1:0]    bump_node;
	logic                 bump_take;
	logic                 emit, node_inc, edge_we, deg_we, pend_load, scan_init;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Range checks and ordering of the incoming pair
	assign a_out = CMP_W'(node_a) >= CMP_W'(node_count_q);
	assign b_out = CMP_W'(node_b) >= CMP_W'(node_count_q);
	assign lo_in = (node_a < node_b) ? node_a : node_b;
	assign hi_in = (node_a < node_b) ? node_b : node_a;

	// Scan read issue and compare stage
	assign full      = (n_q == RESULT_CAP);
	assign issue     = (state_q == S_SCAN) && (rd_idx_q != edge_count_q) && !full;
	assign scan_done = !issue && !rd_vld_s1;
	assign e_lo      = edge_rdata_s1[EDGE_W-1:NODE_W];
	assign e_hi      = edge_rdata_s1[NODE_W-1:0];
	assign dup       = rd_vld_s1 && (e_lo == lo_q) && (e_hi == hi_q);
	assign hit       = rd_vld_s1 && !full && ((e_lo == a_q) || (e_hi == a_q));
	assign other     = (e_lo == a_q) ? e_hi : e_lo;

	// Degree read-modify-write and top node update
	assign deg_raddr = (state_q == S_DEG_LO) ? hi_q[NA_W-1:0] : lo_q[NA_W-1:0];
	assign deg_cur   = deg_rvld_s1 ? deg_rdata_s1 : '0;
	assign deg_new   = deg_cur + DEG_W'(1);
	assign bump_node = (state_q == S_DEG_LO) ? lo_q : hi_q;
	assign bump_take = (deg_new > best_deg_q) ||
	                   ((deg_new == best_deg_q) && (bump_node < best_node_q));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (kind == K_ADD_EDGE && !a_out && !b_out && node_a != node_b) begin
						state_d = S_SCAN;
					end else if (kind == K_LIST && !a_out) begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (kind_q == K_ADD_EDGE) begin
					if (dup) begin
						state_d = S_IDLE;
					end else if (scan_done) begin
						state_d = (edge_count_q == EC_W'(MAX_EDGES)) ? S_IDLE : S_DEG_LO;
					end
				end else if (full || (!hit && scan_done)) begin
					state_d = S_IDLE;
				end
			end
			S_DEG_LO: state_d = S_DEG_HI;
			S_DEG_HI: state_d = S_REPORT;
			S_REPORT: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Outputs and update enables
	always_comb begin
		emit      = 1'b0;
		res_d     = '{status: ST_OK, node_index: '0, neighbour_valid: 1'b0, last: 1'b1};
		node_inc  = 1'b0;
		edge_we   = 1'b0;
		deg_we    = 1'b0;
		pend_load = 1'b0;
		scan_init = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					scan_init = 1'b1;
					case (kind)
						K_ADD_NODE: begin
							emit = 1'b1;
							if (node_count_q == NC_W'(MAX_NODES)) begin
								res_d.status = ST_NODES_FULL;
							end else begin
								res_d.node_index = NODE_W'(node_count_q);
								node_inc         = 1'b1;
							end
						end
						K_ADD_EDGE: begin
							if (a_out || b_out) begin
								emit         = 1'b1;
								res_d.status = ST_RANGE;
							end else if (node_a == node_b) begin
								emit         = 1'b1;
								res_d.status = ST_SELF;
							end
						end
						K_LIST: begin
							if (a_out) begin
								emit         = 1'b1;
								res_d.status = ST_RANGE;
							end
						end
						default: emit = 1'b1;
					endcase
				end
			end
			S_SCAN: begin
				if (kind_q == K_ADD_EDGE) begin
					if (dup) begin
						emit         = 1'b1;
						res_d.status = ST_DUP;
					end else if (scan_done) begin
						if (edge_count_q == EC_W'(MAX_EDGES)) begin
							emit         = 1'b1;
							res_d.status = ST_EDGES_FULL;
						end else begin
							edge_we = 1'b1;
						end
					end
				end else if (full) begin
					emit                  = 1'b1;
					res_d.node_index      = pend_idx_q;
					res_d.neighbour_valid = 1'b1;
				end else if (hit) begin
					pend_load = 1'b1;
					if (pend_vld_q) begin
						emit                  = 1'b1;
						res_d.node_index      = pend_idx_q;
						res_d.neighbour_valid = 1'b1;
						res_d.last            = 1'b0;
					end
				end else if (scan_done) begin
					emit = 1'b1;
					if (pend_vld_q) begin
						res_d.node_index      = pend_idx_q;
						res_d.neighbour_valid = 1'b1;
					end
				end
			end
			S_DEG_LO: deg_we = 1'b1;
			S_DEG_HI: deg_we = 1'b1;
			S_REPORT: emit = 1'b1;
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			node_count_q <= '0;
			edge_count_q <= '0;
			best_node_q  <= '0;
			best_deg_q   <= '0;
			deg_vld_q    <= '0;
			rd_vld_s1    <= 1'b0;
			pend_vld_q   <= 1'b0;
			n_q          <= '0;
			strobe_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			strobe_q  <= emit;
			if (node_inc) begin
				node_count_q <= node_count_q + NC_W'(1);
			end
			if (edge_we) begin
				edge_count_q <= edge_count_q + EC_W'(1);
			end
			// mark the degree entry written and take a new top node
			if (deg_we) begin
				deg_vld_q[bump_node[NA_W-1:0]] <= 1'b1;
				if (bump_take) begin
					best_node_q <= bump_node;
					best_deg_q  <= deg_new;
				end
			end
			if (scan_init) begin
				pend_vld_q <= 1'b0;
				n_q        <= '0;
			end else if (pend_load) begin
				pend_vld_q <= 1'b1;
				n_q        <= n_q + NODE_W'(1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			lo_q   <= lo_in;
			hi_q   <= hi_in;
			a_q    <= node_a;
		end
		// advance the scan address
		if (scan_init) begin
			rd_idx_q <= '0;
		end else if (issue) begin
			rd_idx_q <= rd_idx_q + EC_W'(1);
		end
		if (pend_load) begin
			pend_idx_q <= other;
		end
		if (emit) begin
			res_q <= res_d;
			top_q <= best_node_q;
		end
	end

	// Edge memory: append at edge_count, read one entry per cycle
	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_count_q[EA_W-1:0]] <= {lo_q, hi_q};
		end
		edge_rdata_s1 <= edge_mem[rd_idx_q[EA_W-1:0]];
	end

	// Degree memory: read lo then hi, write back the bumped count
	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[bump_node[NA_W-1:0]] <= deg_new;
		end
		deg_rdata_s1 <= deg_mem[deg_raddr];
		deg_rvld_s1  <= deg_vld_q[deg_raddr];
	end

	// Drive the result ports
	assign strobe          = strobe_q;
	assign status          = res_q.status;
	assign node_index      = res_q.node_index;
	assign neighbour_valid = res_q.neighbour_valid;
	assign last            = res_q.last;
	assign top_node        = top_q;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the undirected edge table. It runs a short table of
// directed requests, then random traffic shaped around the allocated nodes,
// then fills the node store to its limit and probes it. A behavioral model
// inside the bench predicts the results (directed rows may carry a hand-written
// one instead), and a monitor checks each strobed result, field by field,
// against the oldest pending prediction.
module tb_top;
	import uet_pkg::*;

	localparam logic [KIND_W-1:0] K_SPARE = 2'd3;  // undefined request kind
	localparam int RANDOM_ITEMS = 320;
	localparam int AFTER_FILL_ITEMS = 30;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT = 5000000;

	// One expected result
	typedef struct packed {
		status_t           status;
		logic [NODE_W-1:0] node_index;
		logic              nv;
		logic              last;
		logic [NODE_W-1:0] top;
	} edge_reply_t;

	// One request, with an optional hand-written single result
	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
		bit                typed;
		status_t           status;
		logic [NODE_W-1:0] idx;
		logic [NODE_W-1:0] top;
	} request_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [KIND_W-1:0]   kind;
	logic [NODE_W-1:0]   node_a;
	logic [NODE_W-1:0]   node_b;
	logic                strobe;
	logic [STATUS_W-1:0] status;
	logic [NODE_W-1:0]   node_index;
	logic                neighbour_valid;
	logic                last;
	logic [NODE_W-1:0]   top_node;

	// Graph model state
	int pair_lo [MAX_EDGES_DEF];
	int pair_hi [MAX_EDGES_DEF];
	int pair_total;
	int node_total;
	int node_degree [MAX_NODES_DEF];
	int hub_node;
	int hub_degree;
	bit linked [MAX_NODES_DEF][MAX_NODES_DEF];

	edge_reply_t fresh[$];
	edge_reply_t replies_due[$];
	request_t    opening_rows[$];

	int  burst_left;
	int  requests_sent;
	int  results_seen;
	int  fail_count;
	int  cycles;
	int  status_hits [6];

	undirected_edge_table_top u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.node_a          (node_a),
		.node_b          (node_b),
		.strobe          (strobe),
		.status          (status),
		.node_index      (node_index),
		.neighbour_valid (neighbour_valid),
		.last            (last),
		.top_node        (top_node)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	// Queue one predicted result carrying the current top node
	task automatic note(input status_t st, input int idx, input logic nv, input logic lst);
		edge_reply_t r;
		r.status     = st;
		r.node_index = idx[NODE_W-1:0];
		r.nv         = nv;
		r.last       = lst;
		r.top        = hub_node[NODE_W-1:0];
		fresh = {fresh, r};
	endtask

	// Raise the degree of a node and track the top node, lowest index on ties
	task automatic raise_degree(input int x);
		node_degree[x]++;
		if (node_degree[x] > hub_degree || (node_degree[x] == hub_degree && x < hub_node)) begin
			hub_degree = node_degree[x];
			hub_node = x;
		end
	endtask

	// Apply one request to the graph model and collect its results in fresh
	task automatic apply_request(input logic [KIND_W-1:0] k, input int a, input int b);
		int lo;
		int hi;
		int hits;
		int sent;
		int other;
		fresh.delete();
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		case (k)
			K_ADD_NODE: begin
				if (node_total >= MAX_NODES_DEF) begin
					note(ST_NODES_FULL, 0, 1'b0, 1'b1);
				end else begin
					node_total++;
					note(ST_OK, node_total - 1, 1'b0, 1'b1);
				end
			end
			K_ADD_EDGE: begin
				if (a >= node_total || b >= node_total) begin
					note(ST_RANGE, 0, 1'b0, 1'b1);
				end else if (a == b) begin
					note(ST_SELF, 0, 1'b0, 1'b1);
				end else if (linked[lo][hi]) begin
					note(ST_DUP, 0, 1'b0, 1'b1);
				end else if (pair_total >= MAX_EDGES_DEF) begin
					note(ST_EDGES_FULL, 0, 1'b0, 1'b1);
				end else begin
					pair_lo[pair_total] = lo;
					pair_hi[pair_total] = hi;
					pair_total++;
					linked[lo][hi] = 1'b1;
					raise_degree(lo);
					raise_degree(hi);
					note(ST_OK, 0, 1'b0, 1'b1);
				end
			end
			K_LIST: begin
				if (a >= node_total) begin
					note(ST_RANGE, 0, 1'b0, 1'b1);
				end else begin
					// count first so the final neighbor can carry last
					hits = 0;
					for (int i = 0; i < pair_total; i++) begin
						if (pair_lo[i] == a || pair_hi[i] == a)
							hits++;
					end
					if (hits > int'(RESULT_CAP))
						hits = int'(RESULT_CAP);
					sent = 0;
					for (int i = 0; i < pair_total && sent < hits; i++) begin
						if (pair_lo[i] == a || pair_hi[i] == a) begin
							other = (pair_lo[i] == a) ? pair_hi[i] : pair_lo[i];
							sent++;
							note(ST_OK, other, 1'b1, sent == hits);
						end
					end
					if (hits == 0)
						note(ST_OK, 0, 1'b0, 1'b1);
				end
			end
			default: begin
				note(ST_OK, 0, 1'b0, 1'b1);
			end
		endcase
	endtask

	// Drive one request in bursts with random gaps, then predict on transfer
	task automatic send_item(input request_t rq);
		edge_reply_t r;
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
			                                         : $urandom_range(1, 8);
		end
		burst_left--;
		start  <= 1'b1;
		kind   <= rq.kind;
		node_a <= rq.a;
		node_b <= rq.b;
		do @(posedge clk); while (busy !== 1'b0);
		apply_request(rq.kind, int'(rq.a), int'(rq.b));
		if (rq.typed) begin
			r.status     = rq.status;
			r.node_index = rq.idx;
			r.nv         = 1'b0;
			r.last       = 1'b1;
			r.top        = rq.top;
			replies_due = {replies_due, r};
		end else begin
			foreach (fresh[i])
				replies_due = {replies_due, fresh[i]};
		end
		requests_sent++;
	endtask

	// Build a request checked only against the model
	function automatic request_t plain(input logic [KIND_W-1:0] k, input int a, input int b);
		request_t rq;
		rq.kind   = k;
		rq.a      = a[NODE_W-1:0];
		rq.b      = b[NODE_W-1:0];
		rq.typed  = 1'b0;
		rq.status = ST_OK;
		rq.idx    = '0;
		rq.top    = '0;
		return rq;
	endfunction

	// Add one row to the directed table
	task automatic add_row(input logic [KIND_W-1:0] k, input int a, input int b,
	                       input bit typed, input status_t st, input int idx, input int top);
		request_t rq;
		rq = plain(k, a, b);
		rq.typed  = typed;
		rq.status = st;
		rq.idx    = idx[NODE_W-1:0];
		rq.top    = top[NODE_W-1:0];
		opening_rows = {opening_rows, rq};
	endtask

	// Mostly well-formed traffic on allocated nodes, with some noise
	task automatic send_random();
		int pick;
		int a;
		int b;
		int e;
		logic [KIND_W-1:0] k;
		pick = $urandom_range(0, 99);
		a = $urandom_range(0, 63);
		b = $urandom_range(0, 63);
		if (pick < 15) begin
			k = K_ADD_NODE;
		end else if (pick < 65) begin
			k = K_ADD_EDGE;
			if (pair_total > 0 && $urandom_range(0, 9) == 0) begin
				// repeat a stored edge with its ends swapped
				e = $urandom_range(0, pair_total - 1);
				a = pair_hi[e];
				b = pair_lo[e];
			end else if (node_total > 0 && $urandom_range(0, 99) < 85) begin
				a = $urandom_range(0, node_total - 1);
				b = $urandom_range(0, node_total - 1);
			end
		end else if (pick < 95) begin
			k = K_LIST;
			if (node_total > 0 && $urandom_range(0, 99) < 85)
				a = $urandom_range(0, node_total - 1);
		end else begin
			k = K_SPARE;
		end
		send_item(plain(k, a, b));
	endtask

	// Check each strobed result against the oldest prediction
	always @(posedge clk) begin : result_check
		edge_reply_t want;
		if (arst_n === 1'b1 && strobe === 1'b1) begin
			results_seen++;
			if (status < 6)
				status_hits[status]++;
			if (replies_due.size() == 0) begin
				$error("result with no prediction pending: status %0d index %0d",
				       status, node_index);
				fail_count++;
			end else begin
				want = replies_due.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (node_index !== want.node_index) begin
					$error("node_index: expected %0d, got %0d", want.node_index, node_index);
					fail_count++;
				end
				if (neighbour_valid !== want.nv) begin
					$error("neighbour_valid: expected %0d, got %0d", want.nv, neighbour_valid);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					fail_count++;
				end
				if (top_node !== want.top) begin
					$error("top_node: expected %0d, got %0d", want.top, top_node);
					fail_count++;
				end
			end
		end
	end

	// End the run if it stalls
	initial begin : watchdog
		wait (cycles >= CYCLE_LIMIT);
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin : stimulus
		start  <= 1'b0;
		kind   <= K_ADD_NODE;
		node_a <= '0;
		node_b <= '0;
		arst_n = 1'b0;
		cycles = 0;
		pair_total = 0;
		node_total = 0;
		hub_node = 0;
		hub_degree = 0;
		burst_left = 0;
		requests_sent = 0;
		results_seen = 0;
		fail_count = 0;
		foreach (node_degree[i])
			node_degree[i] = 0;
		foreach (status_hits[i])
			status_hits[i] = 0;
		foreach (linked[i, j])
			linked[i][j] = 1'b0;

		// Directed table: empty store, first nodes and edges, range extremes
		add_row(K_LIST,     0,  0,  1, ST_RANGE, 0, 0);
		add_row(K_ADD_EDGE, 0,  1,  1, ST_RANGE, 0, 0);
		add_row(K_SPARE,    63, 63, 1, ST_OK,    0, 0);
		add_row(K_ADD_NODE, 0,  0,  1, ST_OK,    0, 0);
		add_row(K_ADD_NODE, 63, 0,  1, ST_OK,    1, 0);
		add_row(K_LIST,     0,  63, 1, ST_OK,    0, 0);
		add_row(K_ADD_EDGE, 1,  0,  1, ST_OK,    0, 0);
		add_row(K_ADD_EDGE, 0,  1,  1, ST_DUP,   0, 0);
		add_row(K_ADD_EDGE, 1,  1,  1, ST_SELF,  0, 0);
		add_row(K_ADD_EDGE, 2,  0,  1, ST_RANGE, 0, 0);
		add_row(K_ADD_EDGE, 0,  63, 1, ST_RANGE, 0, 0);
		add_row(K_ADD_EDGE, 63, 63, 1, ST_RANGE, 0, 0);
		add_row(K_LIST,     63, 0,  1, ST_RANGE, 0, 0);
		add_row(K_LIST,     1,  0,  0, ST_OK,    0, 0);
		add_row(K_ADD_NODE, 63, 63, 0, ST_OK,    0, 0);
		add_row(K_ADD_EDGE, 2,  1,  0, ST_OK,    0, 0);
		add_row(K_LIST,     1,  0,  0, ST_OK,    0, 0);
		add_row(K_LIST,     2,  63, 0, ST_OK,    0, 0);
		add_row(K_ADD_NODE, 0,  0,  0, ST_OK,    0, 0);
		add_row(K_ADD_EDGE, 3,  0,  0, ST_OK,    0, 0);
		add_row(K_ADD_EDGE, 0,  2,  0, ST_OK,    0, 0);
		add_row(K_LIST,     0,  0,  0, ST_OK,    0, 0);
		add_row(K_SPARE,    0,  0,  0, ST_OK,    0, 0);

		// Hold reset, then release it
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_rows[i])
			send_item(opening_rows[i]);

		for (int n = 0; n < RANDOM_ITEMS; n++)
			send_random();

		// Fill the node store and run one past it
		while (node_total < MAX_NODES_DEF)
			send_item(plain(K_ADD_NODE, $urandom_range(0, 63), $urandom_range(0, 63)));
		send_item(plain(K_ADD_NODE, 0, 0));

		// Probe the top node: add pair 62-63, repeat a stored pair, list node 0
		send_item(plain(K_ADD_EDGE, 62, 63));
		send_item(plain(K_ADD_EDGE, 1, 0));
		send_item(plain(K_LIST, 0, 0));
		for (int n = 0; n < AFTER_FILL_ITEMS; n++)
			send_random();

		// Drop start and drain the pending results
		start <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests, checked %0d results; store ends with %0d nodes, %0d edges.",
		         requests_sent, results_seen, node_total, pair_total);
		$display("Status counts ok/self/dup/range/edges-full/nodes-full: %0d %0d %0d %0d %0d %0d",
		         status_hits[0], status_hits[1], status_hits[2], status_hits[3],
		         status_hits[4], status_hits[5]);
		if (fail_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
